// ----- design/turret_scan_and_track_macros.svh -----
// Assertion macros used by the turret scan-and-track top level.
`ifndef TURRET_SCAN_AND_TRACK_MACROS_SVH
`define TURRET_SCAN_AND_TRACK_MACROS_SVH

// Concurrent assertion on an explicit clock, disabled while the active-low reset is held.
`define TST_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("turret_scan_and_track: assertion failed");

// Concurrent assertion on the standard clock and reset of this design.
`define TST_ASSERT(name, prop) \
  `TST_ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

// ----- design/tst_pkg.sv -----
// Package with types, constants and helper functions of the turret scan-and-track block.
`timescale 1ns / 1ps
`default_nettype none

package tst_pkg;

  localparam int unsigned SENSOR_BITS   = 10;
  localparam int unsigned POSITION_BITS = 12;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = POSITION_BITS;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_TILT_LIMIT       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DETECT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAN_LOW_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAN_HIGH_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_AIM_TOLERANCE    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [POSITION_BITS-1:0] TILT_LIMIT_RST       = POSITION_BITS'(500);
  localparam logic [SENSOR_BITS-1:0]   DETECT_THRESHOLD_RST = SENSOR_BITS'(10);
  localparam logic [POSITION_BITS-1:0] PAN_LOW_LIMIT_RST    = POSITION_BITS'(600);
  localparam logic [POSITION_BITS-1:0] PAN_HIGH_LIMIT_RST   = POSITION_BITS'(1000);
  localparam logic [SENSOR_BITS-1:0]   AIM_TOLERANCE_RST    = SENSOR_BITS'(50);

  // Motion constants.
  localparam logic [POSITION_BITS-1:0] HOME_PAN       = POSITION_BITS'(700);
  localparam logic [POSITION_BITS-1:0] HOME_TILT      = '0;
  localparam logic [POSITION_BITS-1:0] TILT_DOWN_STEP = POSITION_BITS'(10);
  localparam logic [POSITION_BITS-1:0] TILT_UP_STEP   = POSITION_BITS'(50);
  localparam logic [POSITION_BITS-1:0] SWEEP_STEP     = POSITION_BITS'(100);
  localparam logic [POSITION_BITS-1:0] TRACK_STEP     = POSITION_BITS'(50);

  // Mode codes as reported on the result channel.
  localparam logic [1:0] MODE_CODE_HOME   = 2'd0;
  localparam logic [1:0] MODE_CODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_CODE_LOCK   = 2'd2;

  // Controller mode, one-hot.
  typedef enum logic [2:0] {
    MODE_HOME   = 3'b001,
    MODE_SEARCH = 3'b010,
    MODE_LOCK   = 3'b100
  } mode_e;

  typedef struct packed {
    logic [SENSOR_BITS-1:0] upper_left;
    logic [SENSOR_BITS-1:0] upper_right;
    logic [SENSOR_BITS-1:0] middle;
    logic [SENSOR_BITS-1:0] lower_left;
    logic [SENSOR_BITS-1:0] lower_right;
    logic                   tilt_reached;
    logic                   pan_reached;
  } item_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] tilt_target;
    logic [POSITION_BITS-1:0] pan_target;
    logic                     clear_reached;
    logic                     fire;
    logic [1:0]               mode_now;
  } res_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] tilt_limit;
    logic [SENSOR_BITS-1:0]   detect_threshold;
    logic [POSITION_BITS-1:0] pan_low_limit;
    logic [POSITION_BITS-1:0] pan_high_limit;
    logic [SENSOR_BITS-1:0]   aim_tolerance;
  } cfg_t;

  typedef struct packed {
    mode_e                    mode;
    logic [POSITION_BITS-1:0] tilt;
    logic [POSITION_BITS-1:0] pan;
    logic                     sweep_down;
  } state_t;

  // Add with saturation at the top of the position range.
  function automatic logic [POSITION_BITS-1:0] sat_add(
    input logic [POSITION_BITS-1:0] a,
    input logic [POSITION_BITS-1:0] b
  );
    logic [POSITION_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[POSITION_BITS] ? '1 : sum[POSITION_BITS-1:0];
  endfunction

  // Subtract with saturation at zero.
  function automatic logic [POSITION_BITS-1:0] sat_sub(
    input logic [POSITION_BITS-1:0] a,
    input logic [POSITION_BITS-1:0] b
  );
    return (a < b) ? '0 : (a - b);
  endfunction

  // True when the outer reading lies strictly within the tolerance of the center.
  function automatic logic near_center(
    input logic [SENSOR_BITS-1:0] c,
    input logic [SENSOR_BITS-1:0] s,
    input logic [SENSOR_BITS-1:0] tol
  );
    logic [SENSOR_BITS-1:0] diff;
    diff = (c >= s) ? (c - s) : (s - c);
    return diff < tol;
  endfunction

  // Encode the one-hot mode into the reported mode code.
  function automatic logic [1:0] mode_code(input mode_e m);
    logic [1:0] code;
    unique case (m)
      MODE_HOME:   code = MODE_CODE_HOME;
      MODE_SEARCH: code = MODE_CODE_SEARCH;
      MODE_LOCK:   code = MODE_CODE_LOCK;
      default:     code = MODE_CODE_HOME;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- design/tst_if.sv -----
// Valid/ready channel interfaces for sensor items, result items and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

// Channel that carries one sensor item per handshake.
interface tst_in_if;
  logic            valid;
  logic            ready;
  tst_pkg::item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Channel that carries one result item per handshake.
interface tst_out_if;
  logic           valid;
  logic           ready;
  tst_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface tst_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tst_pkg::CFG_IDX_BITS-1:0]   index;
  logic [tst_pkg::CFG_DATA_BITS-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- design/tst_cfg_regs.sv -----
// Configuration register file of the turret scan-and-track block.
`timescale 1ns / 1ps
`default_nettype none

module tst_cfg_regs (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tst_cfg_if.sink        cfg_i,
  output tst_pkg::cfg_t  cfg_o
);

  tst_pkg::cfg_t cfg_q;
  tst_pkg::cfg_t cfg_d;
  logic          wr_en;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  // Decode the register index; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_i.index)
        tst_pkg::REG_TILT_LIMIT:       cfg_d.tilt_limit = cfg_i.wdata;
        tst_pkg::REG_DETECT_THRESHOLD:
          cfg_d.detect_threshold = cfg_i.wdata[tst_pkg::SENSOR_BITS-1:0];
        tst_pkg::REG_PAN_LOW_LIMIT:    cfg_d.pan_low_limit = cfg_i.wdata;
        tst_pkg::REG_PAN_HIGH_LIMIT:   cfg_d.pan_high_limit = cfg_i.wdata;
        tst_pkg::REG_AIM_TOLERANCE:
          cfg_d.aim_tolerance = cfg_i.wdata[tst_pkg::SENSOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register storage with power-on defaults.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tilt_limit       <= tst_pkg::TILT_LIMIT_RST;
      cfg_q.detect_threshold <= tst_pkg::DETECT_THRESHOLD_RST;
      cfg_q.pan_low_limit    <= tst_pkg::PAN_LOW_LIMIT_RST;
      cfg_q.pan_high_limit   <= tst_pkg::PAN_HIGH_LIMIT_RST;
      cfg_q.aim_tolerance    <= tst_pkg::AIM_TOLERANCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/tst_step.sv -----
// Next-state and result logic for one control tick of the turret controller.
`timescale 1ns / 1ps
`default_nettype none

module tst_step (
  input  wire tst_pkg::state_t  state_i,
  input  wire tst_pkg::item_t   item_i,
  input  wire tst_pkg::cfg_t    cfg_i,
  output tst_pkg::state_t       state_o,
  output tst_pkg::res_t         res_o
);

  logic                              both;
  logic                              seen;
  logic                              aligned;
  logic                              left_brighter;
  logic                              right_brighter;
  logic [tst_pkg::POSITION_BITS-1:0] sweep_up_pan;
  logic [tst_pkg::POSITION_BITS-1:0] sweep_dn_pan;
  logic                              clr;
  logic                              fire;

  assign both = item_i.tilt_reached & item_i.pan_reached;

  // Detection: any sensor at or above the threshold.
  assign seen = (item_i.upper_left  >= cfg_i.detect_threshold) ||
                (item_i.upper_right >= cfg_i.detect_threshold) ||
                (item_i.middle      >= cfg_i.detect_threshold) ||
                (item_i.lower_left  >= cfg_i.detect_threshold) ||
                (item_i.lower_right >= cfg_i.detect_threshold);

  // Alignment: all four outer sensors close to the center reading.
  assign aligned =
    tst_pkg::near_center(item_i.middle, item_i.upper_left,  cfg_i.aim_tolerance) &&
    tst_pkg::near_center(item_i.middle, item_i.upper_right, cfg_i.aim_tolerance) &&
    tst_pkg::near_center(item_i.middle, item_i.lower_left,  cfg_i.aim_tolerance) &&
    tst_pkg::near_center(item_i.middle, item_i.lower_right, cfg_i.aim_tolerance);

  assign left_brighter  = (item_i.upper_left  > item_i.middle) ||
                          (item_i.lower_left  > item_i.middle);
  assign right_brighter = (item_i.upper_right > item_i.middle) ||
                          (item_i.lower_right > item_i.middle);

  // Candidate pan positions for the two sweep directions.
  assign sweep_up_pan = tst_pkg::sat_add(state_i.pan, tst_pkg::SWEEP_STEP);
  assign sweep_dn_pan = tst_pkg::sat_sub(state_i.pan, tst_pkg::SWEEP_STEP);

  // Mode sequencer.
  always_comb begin
    state_o = state_i;
    clr     = 1'b0;
    fire    = 1'b0;
    unique case (state_i.mode)
      tst_pkg::MODE_HOME: begin
        state_o.tilt = tst_pkg::HOME_TILT;
        state_o.pan  = tst_pkg::HOME_PAN;
        if (both) begin
          state_o.mode = tst_pkg::MODE_SEARCH;
        end
      end
      tst_pkg::MODE_SEARCH: begin
        if (both) begin
          clr = 1'b1;
          if (state_i.tilt >= cfg_i.tilt_limit) begin
            state_o.tilt = tst_pkg::sat_sub(state_i.tilt, tst_pkg::TILT_DOWN_STEP);
          end else begin
            state_o.tilt = tst_pkg::sat_add(state_i.tilt, tst_pkg::TILT_UP_STEP);
            if (!state_i.sweep_down) begin
              state_o.pan = sweep_up_pan;
              if (sweep_up_pan >= cfg_i.pan_high_limit) begin
                state_o.sweep_down = 1'b1;
              end
            end else begin
              state_o.pan = sweep_dn_pan;
              if (sweep_dn_pan <= cfg_i.pan_low_limit) begin
                state_o.sweep_down = 1'b0;
              end
            end
          end
        end
        if (seen) begin
          state_o.mode = tst_pkg::MODE_LOCK;
        end
      end
      tst_pkg::MODE_LOCK: begin
        if (both) begin
          clr = 1'b1;
          if (aligned) begin
            fire = 1'b1;
          end else if (left_brighter) begin
            state_o.pan = tst_pkg::sat_add(state_i.pan, tst_pkg::TRACK_STEP);
          end else if (right_brighter) begin
            state_o.pan = tst_pkg::sat_sub(state_i.pan, tst_pkg::TRACK_STEP);
          end
        end
      end
      default: ;
    endcase
  end

  // Result item reflects the state after this tick.
  always_comb begin
    res_o.tilt_target   = state_o.tilt;
    res_o.pan_target    = state_o.pan;
    res_o.clear_reached = clr;
    res_o.fire          = fire;
    res_o.mode_now      = tst_pkg::mode_code(state_o.mode);
  end

endmodule

`default_nettype wire

// ----- design/turret_scan_and_track.sv -----
// Top level of the turret scan-and-track controller.
// An accepted item is registered in the input register, and its result in the result register.
// Throughput: one item per cycle while results are taken, limited by the single input register and result register.
// While a finished result waits to be taken, the input register takes at most one more item.
// Reset (rst_ni low, asynchronous): home mode, tilt 0, pan 700, sweep up, default registers.
// No clearing pass is needed after reset; the block is ready for items as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
`include "turret_scan_and_track_macros.svh"

module turret_scan_and_track (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tst_in_if.sink     in_i,
  tst_out_if.source  res_o,
  tst_cfg_if.sink    cfg_i
);

  tst_pkg::cfg_t   cfg;
  tst_pkg::item_t  item_q;
  tst_pkg::res_t   res_q;
  tst_pkg::res_t   step_res;
  tst_pkg::state_t state_q;
  tst_pkg::state_t state_d;
  logic            item_valid_q;
  logic            item_valid_d;
  logic            res_valid_q;
  logic            res_valid_d;
  logic            res_free;
  logic            advance;
  logic            in_acc;
  logic            res_acc;

  // Configuration registers.
  tst_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Tick logic between the input register and the result register.
  tst_step u_step (
    .state_i (state_q),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .res_o   (step_res)
  );

  // Handshake control: the result register frees when empty or being taken.
  assign res_free   = !res_valid_q || res_o.ready;
  assign advance    = item_valid_q && res_free;
  assign in_i.ready = !item_valid_q || res_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign res_acc    = res_valid_q && res_o.ready;

  assign item_valid_d = (item_valid_q && !advance) || in_acc;
  assign res_valid_d  = advance || (res_valid_q && !res_o.ready);

  // Control state and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q       <= 1'b0;
      res_valid_q        <= 1'b0;
      state_q.mode       <= tst_pkg::MODE_HOME;
      state_q.tilt       <= tst_pkg::HOME_TILT;
      state_q.pan        <= tst_pkg::HOME_PAN;
      state_q.sweep_down <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      res_valid_q  <= res_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_i.data;
    end
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // An accepted item is held in the input register in the next cycle.
  `TST_ASSERT(a_accept_loads, in_acc |=> item_valid_q)

  // A taken result with nothing behind it leaves the output empty.
  `TST_ASSERT(a_drain_empties, (res_acc && !item_valid_q) |=> !res_valid_q)

  // Lock-on is never left.
  `TST_ASSERT(a_lock_sticky, (state_q.mode == tst_pkg::MODE_LOCK) |=>
    (state_q.mode == tst_pkg::MODE_LOCK))

  // A fire pulse only comes in lock-on and always consumes the reached flags.
  `TST_ASSERT(a_fire_in_lock, (res_valid_q && res_q.fire) |->
    (res_q.clear_reached && (res_q.mode_now == tst_pkg::MODE_CODE_LOCK)))

endmodule

`default_nettype wire

// ----- dv/turret_scan_and_track_tb.sv -----
// Self-checking testbench for the turret scan-and-track controller.
`timescale 1ns / 1ps

module turret_scan_and_track_tb;
  import tst_pkg::*;

  localparam int POS_TOP     = (1 << POSITION_BITS) - 1;
  localparam int SENSOR_TOP  = (1 << SENSOR_BITS) - 1;
  localparam int DOWN_STEP   = int'(TILT_DOWN_STEP);
  localparam int UP_STEP     = int'(TILT_UP_STEP);
  localparam int SWEEP       = int'(SWEEP_STEP);
  localparam int TRACK       = int'(TRACK_STEP);
  localparam int HOME_PAN_I  = int'(HOME_PAN);
  localparam int STALL_LIMIT = 2000;

  // Direction in which a burst of lock-on readings pushes the pan axis.
  typedef enum int {
    LEAN_NONE,
    LEAN_UP,
    LEAN_DOWN
  } lean_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tst_in_if  in_if ();
  tst_out_if res_if ();
  tst_cfg_if cfg_if ();

  turret_scan_and_track u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk = ~clk;

  // Tracked copy of the controller state and its registers.
  mode_e                    track_mode       = MODE_HOME;
  int                       track_tilt       = 0;
  int                       track_pan        = HOME_PAN_I;
  bit                       track_sweep_down = 1'b0;
  cfg_t                     cur_cfg          = '{
    tilt_limit:       TILT_LIMIT_RST,
    detect_threshold: DETECT_THRESHOLD_RST,
    pan_low_limit:    PAN_LOW_LIMIT_RST,
    pan_high_limit:   PAN_HIGH_LIMIT_RST,
    aim_tolerance:    AIM_TOLERANCE_RST
  };

  item_t reading_q [$];
  res_t  pending_cmds_q [$];

  int items_pushed  = 0;
  int items_taken   = 0;
  int results_seen  = 0;
  int fires_seen    = 0;
  int lock_results  = 0;
  int regs_written  = 0;
  int errors        = 0;
  int stall_cycles  = 0;
  bit in_took       = 1'b0;
  bit cfg_took      = 1'b0;

  function automatic int clamp_pos(input int v);
    if (v < 0) return 0;
    if (v > POS_TOP) return POS_TOP;
    return v;
  endfunction

  // Advances the tracked state by one sensor item and returns the command it yields.
  function automatic res_t aim_and_sweep(input item_t rd);
    res_t                   cmd;
    logic                   both;
    logic                   seen;
    logic                   aligned;
    int                     tilt_n;
    int                     pan_n;
    int                     mid;
    int                     gap;
    logic [SENSOR_BITS-1:0] outer [4];
    cmd = '0;
    both = rd.tilt_reached && rd.pan_reached;
    tilt_n = track_tilt;
    pan_n = track_pan;
    outer = '{rd.upper_left, rd.upper_right, rd.lower_left, rd.lower_right};
    case (track_mode)
      MODE_HOME: begin
        tilt_n = 0;
        pan_n = clamp_pos(HOME_PAN_I);
        if (both) track_mode = MODE_SEARCH;
      end
      MODE_SEARCH: begin
        seen = rd.middle >= cur_cfg.detect_threshold;
        foreach (outer[k]) begin
          if (outer[k] >= cur_cfg.detect_threshold) seen = 1'b1;
        end
        if (both) begin
          cmd.clear_reached = 1'b1;
          if (tilt_n >= int'(cur_cfg.tilt_limit)) begin
            tilt_n = clamp_pos(tilt_n - DOWN_STEP);
          end else begin
            tilt_n = clamp_pos(tilt_n + UP_STEP);
            if (!track_sweep_down) begin
              pan_n = clamp_pos(pan_n + SWEEP);
              if (pan_n >= int'(cur_cfg.pan_high_limit)) track_sweep_down = 1'b1;
            end else begin
              pan_n = clamp_pos(pan_n - SWEEP);
              if (pan_n <= int'(cur_cfg.pan_low_limit)) track_sweep_down = 1'b0;
            end
          end
        end
        // Detection still lets the search move of this tick happen.
        if (seen) track_mode = MODE_LOCK;
      end
      MODE_LOCK: begin
        if (both) begin
          cmd.clear_reached = 1'b1;
          mid = rd.middle;
          aligned = 1'b1;
          foreach (outer[k]) begin
            gap = mid - int'(outer[k]);
            if (gap < 0) gap = -gap;
            if (gap >= int'(cur_cfg.aim_tolerance)) aligned = 1'b0;
          end
          if (aligned) begin
            cmd.fire = 1'b1;
          end else if (rd.upper_left > rd.middle || rd.lower_left > rd.middle) begin
            pan_n = clamp_pos(pan_n + TRACK);
          end else if (rd.upper_right > rd.middle || rd.lower_right > rd.middle) begin
            pan_n = clamp_pos(pan_n - TRACK);
          end
        end
      end
      default: ;
    endcase
    track_tilt = tilt_n;
    track_pan = pan_n;
    cmd.tilt_target = POSITION_BITS'(tilt_n);
    cmd.pan_target = POSITION_BITS'(pan_n);
    case (track_mode)
      MODE_SEARCH: cmd.mode_now = MODE_CODE_SEARCH;
      MODE_LOCK:   cmd.mode_now = MODE_CODE_LOCK;
      default:     cmd.mode_now = MODE_CODE_HOME;
    endcase
    return cmd;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %0d, expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  // Percentage of cycles in which one side holds off, by progress of the run.
  function automatic int stall_pct(input bit receiver);
    if (items_taken < 630) return receiver ? 65 : 10;
    if (items_taken < 1260) return receiver ? 10 : 65;
    return 0;
  endfunction

  // Sensor item driver, fed from the queue of pending items.
  always @(negedge clk) begin : feed_readings
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (reading_q.size() != 0 && $urandom_range(99) >= stall_pct(1'b0)) begin
        in_if.data <= reading_q.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result channel back-pressure.
  always @(negedge clk) begin : drive_ready
    res_if.ready <= rst_n && ($urandom_range(99) >= stall_pct(1'b1));
  end

  // Monitor: register writes, accepted items, result checks and the watchdog.
  always @(posedge clk) begin : watch_channels
    res_t got;
    res_t want;
    bit   moved;
    if (rst_n) begin
      moved = 1'b0;
      in_took = in_if.valid && in_if.ready;
      cfg_took = cfg_if.valid && cfg_if.ready;
      if (cfg_took) begin
        moved = 1'b1;
        case (cfg_if.index)
          REG_TILT_LIMIT:       cur_cfg.tilt_limit = cfg_if.wdata;
          REG_DETECT_THRESHOLD: cur_cfg.detect_threshold = cfg_if.wdata[SENSOR_BITS-1:0];
          REG_PAN_LOW_LIMIT:    cur_cfg.pan_low_limit = cfg_if.wdata;
          REG_PAN_HIGH_LIMIT:   cur_cfg.pan_high_limit = cfg_if.wdata;
          REG_AIM_TOLERANCE:    cur_cfg.aim_tolerance = cfg_if.wdata[SENSOR_BITS-1:0];
          default: ;
        endcase
      end
      // Results leave only after their item was taken, so check before predicting.
      if (res_if.valid && res_if.ready) begin
        moved = 1'b1;
        results_seen++;
        got = res_if.data;
        if (pending_cmds_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item pending", results_seen));
        end else begin
          want = pending_cmds_q.pop_front();
          check_field("tilt_target", got.tilt_target, want.tilt_target);
          check_field("pan_target", got.pan_target, want.pan_target);
          check_field("clear_reached", got.clear_reached, want.clear_reached);
          check_field("fire", got.fire, want.fire);
          check_field("mode_now", got.mode_now, want.mode_now);
          if (want.fire) fires_seen++;
          if (want.mode_now == MODE_CODE_LOCK) lock_results++;
        end
      end
      if (in_took) begin
        moved = 1'b1;
        items_taken++;
        pending_cmds_q.push_back(aim_and_sweep(in_if.data));
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic item_t reading(input int ul, input int ur, input int mid,
                                    input int ll, input int lr, input bit tr, input bit pr);
    item_t rd;
    rd.upper_left = SENSOR_BITS'(ul);
    rd.upper_right = SENSOR_BITS'(ur);
    rd.middle = SENSOR_BITS'(mid);
    rd.lower_left = SENSOR_BITS'(ll);
    rd.lower_right = SENSOR_BITS'(lr);
    rd.tilt_reached = tr;
    rd.pan_reached = pr;
    return rd;
  endfunction

  // Search item whose readings all stay below the detection level.
  function automatic item_t search_reading(input int thr);
    item_t rd;
    rd.upper_left = SENSOR_BITS'($urandom_range(thr - 1, 0));
    rd.upper_right = SENSOR_BITS'($urandom_range(thr - 1, 0));
    rd.middle = SENSOR_BITS'($urandom_range(thr - 1, 0));
    rd.lower_left = SENSOR_BITS'($urandom_range(thr - 1, 0));
    rd.lower_right = SENSOR_BITS'($urandom_range(thr - 1, 0));
    {rd.tilt_reached, rd.pan_reached} = ($urandom_range(99) < 80) ? 2'b11 : 2'($urandom_range(3));
    return rd;
  endfunction

  // Lock-on item: aligned, dark rim, one side brighter, or plain noise.
  function automatic item_t lock_reading(input lean_e lean, input int tol);
    item_t rd;
    int    r;
    int    mid;
    int    lo;
    int    hi;
    bit    left;
    r = $urandom_range(99);
    rd = reading($urandom_range(SENSOR_TOP), $urandom_range(SENSOR_TOP),
                 $urandom_range(SENSOR_TOP), $urandom_range(SENSOR_TOP),
                 $urandom_range(SENSOR_TOP), 1'b0, 1'b0);
    if (r < 15) begin
      mid = $urandom_range(SENSOR_TOP);
      lo = (mid - tol + 1 < 0) ? 0 : mid - tol + 1;
      hi = (mid + tol - 1 > SENSOR_TOP) ? SENSOR_TOP : mid + tol - 1;
      if (tol == 0) begin
        lo = mid;
        hi = mid;
      end
      rd = reading($urandom_range(hi, lo), $urandom_range(hi, lo), mid,
                   $urandom_range(hi, lo), $urandom_range(hi, lo), 1'b0, 1'b0);
    end else if (r < 25) begin
      mid = $urandom_range(SENSOR_TOP);
      rd = reading($urandom_range(mid, 0), $urandom_range(mid, 0), mid,
                   $urandom_range(mid, 0), $urandom_range(mid, 0), 1'b0, 1'b0);
    end else if (r >= 35) begin
      case (lean)
        LEAN_UP:   left = r < 90;
        LEAN_DOWN: left = r >= 90;
        default:   left = r < 65;
      endcase
      mid = $urandom_range(SENSOR_TOP - 1, 0);
      rd.middle = SENSOR_BITS'(mid);
      if (left) begin
        if ($urandom_range(1)) rd.upper_left = SENSOR_BITS'($urandom_range(SENSOR_TOP, mid + 1));
        else rd.lower_left = SENSOR_BITS'($urandom_range(SENSOR_TOP, mid + 1));
      end else begin
        rd.upper_left = SENSOR_BITS'($urandom_range(mid, 0));
        rd.lower_left = SENSOR_BITS'($urandom_range(mid, 0));
        if ($urandom_range(1)) rd.upper_right = SENSOR_BITS'($urandom_range(SENSOR_TOP, mid + 1));
        else rd.lower_right = SENSOR_BITS'($urandom_range(SENSOR_TOP, mid + 1));
      end
    end
    {rd.tilt_reached, rd.pan_reached} = ($urandom_range(99) < 75) ? 2'b11 : 2'($urandom_range(3));
    return rd;
  endfunction

  task automatic send(input item_t rd);
    reading_q.push_back(rd);
    items_pushed++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= CFG_DATA_BITS'(value);
    do @(negedge clk); while (!cfg_took);
    cfg_if.valid <= 1'b0;
    regs_written++;
  endtask

  // Wait until every queued item has been taken and its result checked.
  task automatic drain();
    do @(negedge clk); while (items_taken != items_pushed || pending_cmds_q.size() != 0);
  endtask

  task automatic run_search(input int count);
    @(posedge clk);
    repeat (count) send(search_reading(int'(cur_cfg.detect_threshold)));
    drain();
  endtask

  task automatic run_lock(input int count, input lean_e lean);
    @(posedge clk);
    repeat (count) send(lock_reading(lean, int'(cur_cfg.aim_tolerance)));
    drain();
  endtask

  initial begin : stimulus
    in_if.valid = 1'b0;
    in_if.data = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Home mode: light is ignored, only both flags move on to search.
    @(posedge clk);
    send(reading(1023, 1023, 1023, 1023, 1023, 1'b0, 1'b0));
    send(reading(0, 0, 0, 0, 0, 1'b1, 1'b0));
    send(reading(0, 0, 0, 0, 0, 1'b0, 1'b1));
    send(reading(1023, 1023, 1023, 1023, 1023, 1'b1, 1'b1));
    // Search without both flags holds still; then sweep past both pan limits
    // until tilt reaches its limit and steps back down.
    send(reading(9, 9, 9, 9, 9, 1'b0, 1'b0));
    repeat (12) send(reading(9, 0, 9, 0, 9, 1'b1, 1'b1));
    drain();

    // Tilt limit at zero: tilt walks down and sticks at the floor.
    write_reg(REG_DETECT_THRESHOLD, 1023);
    write_reg(REG_TILT_LIMIT, 0);
    run_search(100);

    // Widest limits: tilt climbs to the ceiling, pan sweeps the full range.
    write_reg(REG_TILT_LIMIT, POS_TOP);
    write_reg(REG_PAN_LOW_LIMIT, 0);
    write_reg(REG_PAN_HIGH_LIMIT, POS_TOP);
    run_search(400);

    // Random limits; the low limit may lie above the high one.
    repeat (4) begin
      write_reg(REG_TILT_LIMIT, $urandom_range(POS_TOP));
      write_reg(REG_PAN_LOW_LIMIT, $urandom_range(POS_TOP));
      write_reg(REG_PAN_HIGH_LIMIT, $urandom_range(POS_TOP));
      write_reg(REG_DETECT_THRESHOLD, $urandom_range(SENSOR_TOP, 512));
      run_search(60);
    end

    // Detection exactly at the threshold together with a search move.
    write_reg(REG_DETECT_THRESHOLD, 10);
    @(posedge clk);
    send(reading(9, 9, 9, 9, 9, 1'b1, 1'b1));
    send(reading(0, 0, 0, 0, 10, 1'b1, 1'b1));
    // Lock-on: fire, just inside and on the tolerance edge, dark rim, each side.
    send(reading(300, 300, 300, 300, 300, 1'b1, 1'b1));
    send(reading(349, 251, 300, 251, 349, 1'b1, 1'b1));
    send(reading(350, 300, 300, 300, 300, 1'b1, 1'b1));
    send(reading(0, 0, 1023, 0, 0, 1'b1, 1'b1));
    send(reading(0, 0, 0, 1023, 0, 1'b1, 1'b1));
    send(reading(0, 1023, 0, 0, 0, 1'b1, 1'b1));
    send(reading(500, 0, 0, 0, 500, 1'b1, 1'b1));
    send(reading(300, 300, 300, 300, 300, 1'b0, 1'b1));
    send(reading(300, 300, 300, 300, 300, 1'b1, 1'b0));
    drain();

    // Long pan walks so tracking saturates at both ends.
    run_lock(250, LEAN_UP);
    run_lock(250, LEAN_DOWN);
    run_lock(250, LEAN_UP);

    // Zero tolerance never fires; search-only registers have no effect now.
    write_reg(REG_AIM_TOLERANCE, 0);
    write_reg(REG_DETECT_THRESHOLD, 0);
    write_reg(REG_PAN_LOW_LIMIT, POS_TOP);
    write_reg(REG_PAN_HIGH_LIMIT, 0);
    run_lock(80, LEAN_NONE);

    write_reg(REG_AIM_TOLERANCE, SENSOR_TOP);
    run_lock(80, LEAN_NONE);

    repeat (4) begin
      write_reg(REG_AIM_TOLERANCE, $urandom_range(200, 1));
      run_lock(50, lean_e'($urandom_range(2)));
    end

    repeat (20) @(negedge clk);
    $display("Ran %0d sensor items through home, search and lock-on;", items_taken);
    $display("%0d fire pulses, %0d lock-on results, %0d results checked, %0d register writes.",
             fires_seen, lock_results, results_seen, regs_written);
    $display("Three stall mixes covered; %0d mismatches.", errors);
    if (errors == 0 && pending_cmds_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/tst_pkg.sv
design/tst_if.sv
design/tst_cfg_regs.sv
design/tst_step.sv
design/turret_scan_and_track.sv
dv/turret_scan_and_track_tb.sv
